// File: design/ptgm_pkg.sv
package ptgm_pkg;

  localparam int LUT_ENTRIES    = 65536;
  localparam int LUT_ADDR_W     = $clog2(LUT_ENTRIES);
  localparam int IN_FRAC_BITS   = 16;
  localparam int GAIN_FRAC_BITS = 12;

  localparam int CHAN_W  = 20;
  localparam int GAIN_W  = 16;
  localparam int OUT_W   = 16;
  localparam int LANES   = 3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = GAIN_W;

  localparam int IN_FIELDS_W  = 2 * OUT_W + LANES * CHAN_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = LANES * OUT_W;
  localparam int CHAN_LSB     = 2 * OUT_W;

  // Fixed-point widths of the tone curve
  localparam int SC      = IN_FRAC_BITS + 2 * GAIN_FRAC_BITS;
  localparam int PROD_W  = CHAN_W + GAIN_W;
  localparam int DIFF_W  = PROD_W + 1;
  localparam int LO_W    = 18;
  localparam int LOP_W   = LO_W + GAIN_W;
  localparam int HIP_W   = DIFF_W - LO_W + GAIN_W + 1;
  localparam int NUM_W   = DIFF_W + GAIN_W + 1;

  localparam logic signed [DIFF_W-1:0] HALF_IN =
    DIFF_W'(64'd1 << (IN_FRAC_BITS + GAIN_FRAC_BITS - 1));
  localparam logic signed [NUM_W-1:0] HALF_OUT = NUM_W'(64'd1 << (SC - 1));

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 1'b0,
    REG_CONTRAST   = 1'b1
  } reg_idx_t;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_PIXEL = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                 mode;
    logic [LUT_ADDR_W-1:0] idx;
    logic [OUT_W-1:0]      val;
  } ctl_t;

  function automatic logic [LUT_ADDR_W-1:0] quantize(input logic signed [NUM_W-1:0] num);
    logic [SC+OUT_W-1:0] scaled;
    logic [LUT_ADDR_W-1:0] q;
    scaled = {num[SC-1:0], OUT_W'(0)} - (SC + OUT_W)'(num[SC-1:0]);
    if (num[NUM_W-1] || num == '0) begin
      q = '0;
    end else if (num[NUM_W-2:SC] != '0) begin
      q = '1;
    end else begin
      q = scaled[SC+OUT_W-1:SC];
    end
    return q;
  endfunction

endpackage

// File: design/pixel_tone_gamma_map.sv
// Brightness, contrast and gamma tone map for RGB pixels in unsigned Q4.16. Each input
// transfer either loads one gamma table entry (tuser low) or maps one pixel (tuser high);
// only pixels give an output transfer. One transfer is taken per clock cycle unless the output
// stalls; a pixel passes six register stages (gain multiply, offset, contrast partial
// products, sum, quantize, and the synchronous read of the table) before its output is valid.
// The table is held in two copies, one read at two addresses for red and green and one read
// for blue, and every load writes both in the cycle its item reaches the read stage, so a
// pixel behind a load always sees it. The table is not cleared at reset: entries a pixel
// reads must have been loaded first. Write brightness and contrast (unsigned Q4.12, reset
// 1.0) only while no transfer is in flight.
module pixel_tone_gamma_map
  import ptgm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,

  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,

  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // table_index, table_value, red_in, green_in, blue_in, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic                   s_axis_tuser,

  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // red_out, green_out, blue_out
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [GAIN_W-1:0] brightness;
  logic [GAIN_W-1:0] contrast;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= GAIN_ONE;
      contrast   <= GAIN_ONE;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_BRIGHTNESS: brightness <= cfg_data;
        REG_CONTRAST:   contrast   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic va, vb, vc, vd, ve, vf;
  ctl_t ctl_a, ctl_b, ctl_c, ctl_d, ctl_e;
  logic accept, move_a, move_b, move_c, move_d, move_e;
  logic take_b, take_c, take_d, take_e;

  logic [OUT_W-1:0] lut_rg [LUT_ENTRIES];
  logic [OUT_W-1:0] lut_b  [LUT_ENTRIES];
  logic [OUT_W-1:0] rd_r, rd_g, rd_b;

  assign move_e = ve && (ctl_e.mode == MODE_LOAD || !vf || m_axis_tready);
  assign take_e = !ve || move_e;
  assign move_d = vd && take_e;
  assign take_d = !vd || move_d;
  assign move_c = vc && take_d;
  assign take_c = !vc || move_c;
  assign move_b = vb && take_c;
  assign take_b = !vb || move_b;
  assign move_a = va && take_b;

  assign s_axis_tready = !va || take_b;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = vf;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
    end else begin
      va <= accept || (va && !move_a);
      vb <= move_a || (vb && !move_b);
      vc <= move_b || (vc && !move_c);
      vd <= move_c || (vd && !move_d);
      ve <= move_d || (ve && !move_e);
      if (move_e && ctl_e.mode == MODE_PIXEL) begin
        vf <= 1'b1;
      end else if (m_axis_tready) begin
        vf <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl_a.mode <= mode_t'(s_axis_tuser);
      ctl_a.idx  <= s_axis_tdata[LUT_ADDR_W-1:0];
      ctl_a.val  <= s_axis_tdata[OUT_W +: OUT_W];
    end
    if (move_a) ctl_b <= ctl_a;
    if (move_b) ctl_c <= ctl_b;
    if (move_c) ctl_d <= ctl_c;
    if (move_d) ctl_e <= ctl_d;
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [CHAN_W-1:0]         chan;
    logic [PROD_W-1:0]         prod_a;
    logic signed [DIFF_W-1:0]  diff_b;
    logic [LOP_W-1:0]          lo_c;
    logic signed [HIP_W-1:0]   hi_c;
    logic signed [NUM_W-1:0]   num_d;
    logic [LUT_ADDR_W-1:0]     q_e;

    assign chan = s_axis_tdata[CHAN_LSB + i * CHAN_W +: CHAN_W];

    always_ff @(posedge clk) begin
      if (accept) begin
        prod_a <= PROD_W'(chan) * PROD_W'(brightness);
      end
      if (move_a) begin
        diff_b <= $signed({1'b0, prod_a}) - HALF_IN;
      end
      if (move_b) begin
        lo_c <= LOP_W'(diff_b[LO_W-1:0]) * LOP_W'(contrast);
        hi_c <= HIP_W'($signed(diff_b[DIFF_W-1:LO_W])) * HIP_W'($signed({1'b0, contrast}));
      end
      if (move_c) begin
        num_d <= (NUM_W'(hi_c) <<< LO_W) + $signed(NUM_W'(lo_c)) + HALF_OUT;
      end
      if (move_d) begin
        q_e <= quantize(num_d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move_e) begin
      if (ctl_e.mode == MODE_LOAD) begin
        lut_rg[ctl_e.idx] <= ctl_e.val;
      end else begin
        rd_r <= lut_rg[g_lane[0].q_e];
        rd_g <= lut_rg[g_lane[1].q_e];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move_e) begin
      if (ctl_e.mode == MODE_LOAD) begin
        lut_b[ctl_e.idx] <= ctl_e.val;
      end else begin
        rd_b <= lut_b[g_lane[2].q_e];
      end
    end
  end

  assign m_axis_tdata = {rd_b, rd_g, rd_r};

endmodule
